// ===== sv/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// Display register stack package
// Shared field widths, command and status codes, and the control struct
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package drs_pkg;

   localparam int CommandWidth    = 2;
   localparam int BlockIdentWidth = 32;
   localparam int LevelWidth      = 8;
   localparam int SlotWidth       = 8;
   localparam int ValueWidth      = 64;
   localparam int StatusWidth     = 3;
   localparam int NewDepthWidth   = 5;

   // Wide enough to compare any level or slot index with any depth or count.
   localparam int CompareWidth    = 9;

   typedef enum logic [CommandWidth-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_STORE  = 2'd3
   } command_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_BAD_LEVEL = 3'd3,
      STATUS_BAD_SLOT  = 3'd4
   } status_type;

   typedef struct packed {
      logic take;
      logic clear;
   } ctrl_cmd_type;

endpackage

// ===== sv/drs_if.sv =====
// ----------------------------------------------------------------------------
// Display register stack channels
// Valid/ready channels for commands and for results.
// ----------------------------------------------------------------------------
interface drs_req_if
   import drs_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CommandWidth-1:0]    command;
   logic [BlockIdentWidth-1:0] block_ident;
   logic [LevelWidth-1:0]      level;
   logic [SlotWidth-1:0]       slot;
   logic [ValueWidth-1:0]      write_value;

   modport source (output valid, command, block_ident, level, slot, write_value,
                   input ready);
   modport sink   (input valid, command, block_ident, level, slot, write_value,
                   output ready);
endinterface

interface drs_rsp_if
   import drs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [StatusWidth-1:0]   status;
   logic [ValueWidth-1:0]    read_value;
   logic [NewDepthWidth-1:0] new_depth;

   modport source (output valid, status, read_value, new_depth, input ready);
   modport sink   (input valid, status, read_value, new_depth, output ready);
endinterface

// ===== sv/drs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Display register stack controller
// Takes one command transfer, zeroes the slots of a newly pushed frame, then
// holds the result until its transfer.
// ----------------------------------------------------------------------------
module drs_ctrl
   import drs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic         push_go,
   input  logic         clear_last,
   output ctrl_cmd_type ctrl_cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CLEAR = 3'b010,
      S_SEND  = 3'b100
   } ctl_state_type;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_SEND);
   assign ctrl_cmd.take  = req_valid && req_ready;
   assign ctrl_cmd.clear = (state_ff == S_CLEAR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = push_go ? S_CLEAR : S_SEND;
            end
         end
         S_CLEAR: begin
            if (clear_last) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/drs_dpath.sv =====
// ----------------------------------------------------------------------------
// Display register stack datapath
// Depth counter, per-frame used counts, slot memory with a counter that
// zeroes a newly pushed frame, and the result registers.
// ----------------------------------------------------------------------------
module drs_dpath
   import drs_pkg::*;
#(
   parameter int MAX_LEVELS      = 16,
   parameter int SLOTS_PER_FRAME = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             ctrl_cmd,
   input  logic [CommandWidth-1:0]  command,
   input  logic [LevelWidth-1:0]    level,
   input  logic [SlotWidth-1:0]     slot,
   input  logic [ValueWidth-1:0]    write_value,
   output logic                     push_go,
   output logic                     clear_last,
   output logic [StatusWidth-1:0]   status,
   output logic [ValueWidth-1:0]    read_value,
   output logic [NewDepthWidth-1:0] new_depth
);

   localparam int DEPTH_W = $clog2(MAX_LEVELS + 1);
   localparam int CNT_W   = $clog2(SLOTS_PER_FRAME + 1);
   localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int SLOT_W  = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;
   localparam int MEM_DEPTH = MAX_LEVELS * (2 ** SLOT_W);

   logic [DEPTH_W-1:0]         depth_ff;
   logic [DEPTH_W-1:0]         depth_in;
   logic [CNT_W-1:0]           used_ff [MAX_LEVELS];
   logic [ValueWidth-1:0]      mem [MEM_DEPTH];
   logic [ValueWidth-1:0]      rdata_ff;
   logic                       use_mem_ff;
   logic                       use_mem_in;
   status_type                 status_ff;
   status_type                 status_in;
   logic [LVL_W-1:0]           clr_lvl_ff;
   logic [SLOT_W-1:0]          clr_ff;

   logic [CompareWidth-1:0]    depth_ext;
   logic [CompareWidth-1:0]    level_ext;
   logic [CompareWidth-1:0]    slot_ext;
   logic [CompareWidth-1:0]    used_ext;
   logic [LVL_W-1:0]           lvl_idx;
   logic [LVL_W-1:0]           top_idx;
   logic [SLOT_W-1:0]          slot_idx;
   logic [LVL_W+SLOT_W-1:0]    mem_addr;
   logic [LVL_W+SLOT_W-1:0]    clr_addr;
   logic                       level_ok;
   logic                       push_ok;
   logic                       store_ok;
   command_type                cmd;

   assign cmd        = command_type'(command);
   assign depth_ext  = CompareWidth'(depth_ff);
   assign level_ext  = CompareWidth'(level);
   assign slot_ext   = CompareWidth'(slot);
   assign lvl_idx    = level[LVL_W-1:0];
   assign top_idx    = depth_ff[LVL_W-1:0];
   assign slot_idx   = slot[SLOT_W-1:0];
   assign mem_addr   = {lvl_idx, slot_idx};
   assign clr_addr   = {clr_lvl_ff, clr_ff};
   assign used_ext   = CompareWidth'(used_ff[lvl_idx]);
   assign level_ok   = (level_ext < depth_ext);
   assign push_go    = push_ok;
   assign clear_last = (clr_ff == SLOT_W'(SLOTS_PER_FRAME - 1));

   always_comb begin
      depth_in   = depth_ff;
      status_in  = STATUS_OK;
      use_mem_in = 1'b0;
      push_ok    = 1'b0;
      store_ok   = 1'b0;
      unique case (cmd)
         CMD_PUSH: begin
            if (depth_ext >= CompareWidth'(MAX_LEVELS)) begin
               status_in = STATUS_FULL;
            end else begin
               push_ok  = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (depth_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               depth_in = depth_ff - 1'b1;
            end
         end
         CMD_LOOKUP: begin
            if (!level_ok) begin
               status_in = STATUS_BAD_LEVEL;
            end else if (slot_ext >= used_ext) begin
               status_in = STATUS_BAD_SLOT;
            end else begin
               use_mem_in = 1'b1;
            end
         end
         CMD_STORE: begin
            if (!level_ok) begin
               status_in = STATUS_BAD_LEVEL;
            end else if (slot_ext >= CompareWidth'(SLOTS_PER_FRAME)) begin
               status_in = STATUS_BAD_SLOT;
            end else begin
               store_ok = 1'b1;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         clr_lvl_ff <= '0;
         clr_ff     <= '0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            used_ff[i] <= '0;
         end
      end else if (ctrl_cmd.take) begin
         depth_ff <= depth_in;
         if (push_ok) begin
            used_ff[top_idx] <= '0;
            clr_lvl_ff       <= top_idx;
            clr_ff           <= '0;
         end
         if (store_ok) begin
            if (slot_ext >= used_ext) begin
               used_ff[lvl_idx] <= CNT_W'(slot_ext + CompareWidth'(1));
            end
         end
      end else if (ctrl_cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.take) begin
         if (store_ok) begin
            mem[mem_addr] <= write_value;
         end
         rdata_ff <= mem[mem_addr];
      end else if (ctrl_cmd.clear) begin
         mem[clr_addr] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.take) begin
         status_ff  <= status_in;
         use_mem_ff <= use_mem_in;
      end
   end

   assign status     = status_ff;
   assign read_value = use_mem_ff ? rdata_ff : '0;
   assign new_depth  = depth_ext[NewDepthWidth-1:0];

endmodule

// ===== sv/display_register_stack.sv =====
// ----------------------------------------------------------------------------
// Display register stack
// A stack of lexical frames addressed by level, with push, pop, slot lookup
// and slot store commands.
//
// Commands arrive on the req_ch channel and each gives exactly one result on
// the rsp_ch channel, in order. A new command is taken only once the previous
// result has been transferred. Pop, lookup, store and a push on a full stack
// present their registered result in the cycle after the command transfer.
// A successful push first zeroes the new frame's slots in the single-port
// slot memory, one slot per cycle, and then presents its result.
// Reset clears the depth and the used counts; the slot memory needs no
// clearing after reset because every frame is zeroed when it is pushed.
// While the receiver stalls, the result holds and no command is taken.
// ----------------------------------------------------------------------------
module display_register_stack
   import drs_pkg::*;
#(
   parameter int MAX_LEVELS      = 16,
   parameter int SLOTS_PER_FRAME = 32
) (
   input  logic       clock,
   input  logic       reset,
   drs_req_if.sink    req_ch,
   drs_rsp_if.source  rsp_ch
);

   ctrl_cmd_type ctrl_cmd;
   logic         push_go;
   logic         clear_last;

   drs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .push_go    (push_go),
      .clear_last (clear_last),
      .ctrl_cmd   (ctrl_cmd)
   );

   drs_dpath #(
      .MAX_LEVELS      (MAX_LEVELS),
      .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl_cmd    (ctrl_cmd),
      .command     (req_ch.command),
      .level       (req_ch.level),
      .slot        (req_ch.slot),
      .write_value (req_ch.write_value),
      .push_go     (push_go),
      .clear_last  (clear_last),
      .status      (rsp_ch.status),
      .read_value  (rsp_ch.read_value),
      .new_depth   (rsp_ch.new_depth)
   );

endmodule
